[hw/rtl/vctcxo_dac_discipline_defines.svh]
// Assertion macros for the oscillator trim controller.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef VCTCXO_DAC_DISCIPLINE_DEFINES_SVH
`define VCTCXO_DAC_DISCIPLINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DACD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DACD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/dacd_pkg.sv]
// Shared types and constants of the oscillator trim controller.
// No dependencies; imported by every module of the block.
package dacd_pkg;

   localparam int CODE_W     = 16;
   localparam int LOCK_CNT_W = 8;
   localparam int THRESH_W   = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int PROD_W     = 48;

   localparam logic [CODE_W-1:0] MID_CODE = 16'h8000;
   localparam logic [CODE_W-1:0] CODE_MAX = 16'hFFFF;
   localparam logic [CODE_W-1:0] CODE_MIN = 16'h0000;

   // floor(x/5) == (x * 52429) >> 18 for every 16-bit x
   localparam logic [CODE_W-1:0] DIV5_RECIP = 16'd52429;
   localparam int                DIV5_SHIFT = 18;

   localparam logic                  RST_AUTO_ADJUST    = 1'b1;
   localparam logic                  RST_FIXED_DAC      = 1'b0;
   localparam logic                  RST_GRADUAL_MODE   = 1'b1;
   localparam logic [CODE_W-1:0]     RST_TRIM_GAIN      = 16'd2600;
   localparam logic [THRESH_W-1:0]   RST_LOCK_THRESHOLD = 24'd1342177;

   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_ADJUST    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_DAC      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRADUAL_MODE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIM_GAIN      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCK_THRESHOLD = 3'd4;

   typedef enum logic [1:0] {
      OP_PPM_REPORT = 2'd0,
      OP_SLEW_TICK  = 2'd1,
      OP_SAVE_TICK  = 2'd2,
      OP_DAC_WRITE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      EVT_NONE   = 2'd0,
      EVT_LOCKED = 2'd1,
      EVT_LOST   = 2'd2
   } lock_evt_type;

   typedef struct packed {
      op_type              op;
      logic signed [31:0]  ppm_error;
      logic [CODE_W-1:0]   dac_code_in;
   } req_payload_type;

   typedef struct packed {
      logic [CODE_W-1:0] dac_code;
      logic [CODE_W-1:0] target_code;
      logic              is_locked;
      lock_evt_type      lock_event;
      logic              saturated;
      logic              default_saved;
      logic [CODE_W-1:0] default_code;
   } rsp_payload_type;

   typedef struct packed {
      logic                auto_adjust;
      logic                fixed_dac;
      logic                gradual_mode;
      logic [CODE_W-1:0]   trim_gain;
      logic [THRESH_W-1:0] lock_threshold;
   } cfg_type;

   // Item after the first stage: product and lock test already worked out.
   typedef struct packed {
      op_type                    op;
      logic [CODE_W-1:0]         dac_code_in;
      logic signed [PROD_W-1:0]  product;
      logic                      below_thresh;
   } prep_type;

endpackage

[hw/rtl/dacd_csr.sv]
// Configuration registers of the oscillator trim controller.
// Depends on dacd_pkg.
module dacd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [dacd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dacd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output dacd_pkg::cfg_type                   cfg
);
   import dacd_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_AUTO_ADJUST:    cfg_in.auto_adjust    = csr_wdata[0];
            CSR_FIXED_DAC:      cfg_in.fixed_dac      = csr_wdata[0];
            CSR_GRADUAL_MODE:   cfg_in.gradual_mode   = csr_wdata[0];
            CSR_TRIM_GAIN:      cfg_in.trim_gain      = csr_wdata[CODE_W-1:0];
            CSR_LOCK_THRESHOLD: cfg_in.lock_threshold = csr_wdata[THRESH_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{auto_adjust: RST_AUTO_ADJUST, fixed_dac: RST_FIXED_DAC,
                     gradual_mode: RST_GRADUAL_MODE, trim_gain: RST_TRIM_GAIN,
                     lock_threshold: RST_LOCK_THRESHOLD};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hw/rtl/dacd_prep.sv]
// Input stage: registers an accepted item with its gain product and lock test.
// Depends on dacd_pkg.
module dacd_prep (
   input  logic                      clock,
   input  logic                      load,
   input  dacd_pkg::req_payload_type req_payload,
   input  dacd_pkg::cfg_type         cfg,
   output dacd_pkg::prep_type        prep
);
   import dacd_pkg::*;

   prep_type           prep_ff, prep_in;
   logic signed [48:0] prod_full;
   logic [31:0]        ppm_mag;

   always_comb begin
      prod_full = req_payload.ppm_error * $signed({1'b0, cfg.trim_gain});
      // magnitude as unsigned: the most negative value gives 2^31
      ppm_mag   = req_payload.ppm_error[31] ? (~req_payload.ppm_error + 32'd1)
                                            : req_payload.ppm_error;
      prep_in.op           = req_payload.op;
      prep_in.dac_code_in  = req_payload.dac_code_in;
      prep_in.product      = prod_full[PROD_W-1:0];
      prep_in.below_thresh = ppm_mag < {8'd0, cfg.lock_threshold};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prep_ff <= prep_in;
      end
   end

   assign prep = prep_ff;

endmodule

[hw/rtl/dacd_core.sv]
// Controller state (codes, lock counter, default) and the result register.
// Depends on dacd_pkg.
module dacd_core #(
   parameter int LOCK_LIMIT = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  dacd_pkg::prep_type        prep,
   input  dacd_pkg::cfg_type         cfg,
   output dacd_pkg::rsp_payload_type rsp_payload
);
   import dacd_pkg::*;

   localparam logic [LOCK_CNT_W-1:0] LOCK_FULL = LOCK_CNT_W'(LOCK_LIMIT);

   logic [CODE_W-1:0]     cur_ff, cur_in;
   logic [CODE_W-1:0]     tgt_ff, tgt_in;
   logic [CODE_W-1:0]     dflt_ff, dflt_in;
   logic [LOCK_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  pend_ff, pend_in;
   rsp_payload_type       rsp_ff, rsp_in;

   logic signed [49:0]    value;
   logic [CODE_W-1:0]     rpt_code;
   logic [16:0]           diff;
   logic [CODE_W-1:0]     diff_mag;
   logic [31:0]           div_prod;
   logic [CODE_W-1:0]     step;
   logic [CODE_W:0]       dflt_sum;
   lock_evt_type          evt;
   logic                  sat;
   logic                  saved;

   // report arithmetic: current code in Q24 less the gain product, floored and clamped to the code range
   always_comb begin
      value = $signed({10'd0, cur_ff, 24'd0}) - {{2{prep.product[PROD_W-1]}}, prep.product};
      if (value[49]) begin
         rpt_code = CODE_MIN;
      end else if (|value[48:40]) begin
         rpt_code = CODE_MAX;
      end else begin
         rpt_code = value[39:24];
      end
   end

   // slew step: a fifth of the distance, truncated, never less than one
   always_comb begin
      diff     = {1'b0, tgt_ff} - {1'b0, cur_ff};
      diff_mag = diff[16] ? CODE_W'(-diff) : diff[CODE_W-1:0];
      div_prod = diff_mag * DIV5_RECIP;
      step     = CODE_W'(div_prod[31:DIV5_SHIFT]);
      if (step == '0) begin
         step = CODE_W'(1);
      end
      dflt_sum = {1'b0, dflt_ff} + {1'b0, cur_ff};
   end

   always_comb begin
      cur_in  = cur_ff;
      tgt_in  = tgt_ff;
      dflt_in = dflt_ff;
      cnt_in  = cnt_ff;
      pend_in = pend_ff;
      evt     = EVT_NONE;
      sat     = 1'b0;
      saved   = 1'b0;
      case (prep.op)
         OP_PPM_REPORT: begin
            if (cfg.auto_adjust) begin
               if (prep.below_thresh) begin
                  if (cnt_ff != LOCK_FULL) begin
                     cnt_in = cnt_ff + LOCK_CNT_W'(1);
                     if (cnt_in == LOCK_FULL) begin
                        evt = EVT_LOCKED;
                     end
                  end
               end else begin
                  if (cnt_ff == LOCK_FULL) begin
                     evt = EVT_LOST;
                  end
                  cnt_in = '0;
               end
               sat    = (rpt_code == CODE_MIN) || (rpt_code == CODE_MAX);
               tgt_in = rpt_code;
               if (!cfg.gradual_mode) begin
                  cur_in = rpt_code;
               end
            end
         end
         OP_SLEW_TICK: begin
            if (cfg.gradual_mode && !cfg.fixed_dac && (diff != '0)) begin
               cur_in = diff[16] ? (cur_ff - step) : (cur_ff + step);
            end
         end
         OP_SAVE_TICK: begin
            if (pend_ff && (cnt_ff == LOCK_FULL)) begin
               dflt_in = dflt_sum[CODE_W:1];
               pend_in = 1'b0;
               saved   = 1'b1;
            end
         end
         OP_DAC_WRITE: begin
            cur_in = prep.dac_code_in;
            tgt_in = prep.dac_code_in;
         end
         default: begin
            cur_in = cur_ff;
         end
      endcase

      rsp_in.dac_code      = cur_in;
      rsp_in.target_code   = tgt_in;
      rsp_in.is_locked     = (cnt_in == LOCK_FULL);
      rsp_in.lock_event    = evt;
      rsp_in.saturated     = sat;
      rsp_in.default_saved = saved;
      rsp_in.default_code  = dflt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= MID_CODE;
         tgt_ff  <= MID_CODE;
         dflt_ff <= MID_CODE;
         cnt_ff  <= '0;
         pend_ff <= 1'b1;
      end else if (advance) begin
         cur_ff  <= cur_in;
         tgt_ff  <= tgt_in;
         dflt_ff <= dflt_in;
         cnt_ff  <= cnt_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

[hw/rtl/vctcxo_dac_discipline.sv]
// Trim controller for a voltage-trimmed crystal oscillator DAC. Each transfer
// on req_ carries one operation (ppm report, slew tick, save tick or direct
// DAC write) and yields exactly one transfer on rsp_ with the codes, lock
// state and flags after that operation. Throughput is one item per clock while
// rsp_ is not back-pressured. An item passes through the input register,
// where the 32x16 gain product and the lock-threshold compare are formed,
// and then through the state update, where the new code is floored,
// clamped or slewed and the result register is loaded. Back
// pressure on rsp_ holds both stages; the input stage still takes one more
// item while a result waits. Configuration via csr_ is taken at any time
// but should only be written when no item is in flight.
`include "vctcxo_dac_discipline_defines.svh"

module vctcxo_dac_discipline #(
   parameter int LOCK_LIMIT = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  dacd_pkg::req_payload_type          req_payload,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output dacd_pkg::rsp_payload_type          rsp_payload,
   // configuration writes
   input  logic                               csr_wr_en,
   input  logic [dacd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dacd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import dacd_pkg::*;

   cfg_type  cfg;
   prep_type prep;

   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;   // result register can take a new item this cycle
   logic s1_adv;     // input-stage item moves into the state stage
   logic req_xfer;

   // Flow control: result register empties on a transfer, the input stage
   // drains into it when free, and a new request refills the input stage.
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      s1_adv       = s1_valid_ff && out_free;
      req_ready    = !s1_valid_ff || out_free;
      req_xfer     = req_valid && req_ready;
      s1_valid_in  = req_xfer || (s1_valid_ff && !s1_adv);
      rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   dacd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Input register with gain product and lock test
   dacd_prep u_prep (
      .clock       (clock),
      .load        (req_xfer),
      .req_payload (req_payload),
      .cfg         (cfg),
      .prep        (prep)
   );

   // Controller state and result register; state moves only with an item
   dacd_core #(
      .LOCK_LIMIT (LOCK_LIMIT)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (s1_adv),
      .prep        (prep),
      .cfg         (cfg),
      .rsp_payload (rsp_payload)
   );

   // Lock entry is reported together with the locked state, loss without it
   `DACD_ASSERT_IMP(a_evt_locked, clock, reset, rsp_valid && (rsp_payload.lock_event == EVT_LOCKED), rsp_payload.is_locked, "lock entered without lock")
   `DACD_ASSERT_IMP(a_evt_lost, clock, reset, rsp_valid && (rsp_payload.lock_event == EVT_LOST), !rsp_payload.is_locked, "lock lost while still locked")
   // Saturation only flags a target at either end of the range
   `DACD_ASSERT_IMP(a_sat_range, clock, reset, rsp_valid && rsp_payload.saturated, (rsp_payload.target_code == CODE_MIN) || (rsp_payload.target_code == CODE_MAX), "saturation flagged off the rails")
   // A default is saved only while locked
   `DACD_ASSERT_IMP(a_save_locked, clock, reset, rsp_valid && rsp_payload.default_saved, rsp_payload.is_locked, "default saved without lock")
   // A blocked input-stage item is not dropped
   `DACD_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !s1_adv, s1_valid_ff, "input stage item lost under back pressure")

endmodule
